// ===== rtl/core/rpbu_pkg.sv =====
// shared types, codes and constants of the rgb pixel blend unit
package rpbu_pkg;

	localparam int NUM_CH = 3;
	localparam int CH_BLUE = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_RED = 2;

	localparam logic [3:0] ACT_MUL = 4'd0;
	localparam logic [3:0] ACT_SCREEN = 4'd1;
	localparam logic [3:0] ACT_SUB = 4'd2;
	localparam logic [3:0] ACT_ADD = 4'd3;
	localparam logic [3:0] ACT_OVERLAY = 4'd4;
	localparam logic [3:0] ACT_ONLY_R = 4'd5;
	localparam logic [3:0] ACT_ONLY_G = 4'd6;
	localparam logic [3:0] ACT_ONLY_B = 4'd7;
	localparam logic [3:0] ACT_ADDCH_R = 4'd8;
	localparam logic [3:0] ACT_ADDCH_G = 4'd9;
	localparam logic [3:0] ACT_ADDCH_B = 4'd10;
	localparam logic [3:0] ACT_SCALE_R = 4'd11;
	localparam logic [3:0] ACT_SCALE_G = 4'd12;
	localparam logic [3:0] ACT_SCALE_B = 4'd13;
	localparam logic [3:0] ACT_COMBINE = 4'd14;
	localparam logic [3:0] ACT_NONE = 4'd15;

	localparam logic REG_OFFSET = 1'b0;
	localparam logic REG_GAIN = 1'b1;

	localparam logic signed [8:0] OFFSET_RESET = 9'sd0;
	localparam logic [15:0] GAIN_RESET = 16'd256;

	localparam logic [15:0] PROD_MAX = 16'd65025;     // 255 * 255
	localparam logic [16:0] ROUND_BIAS = 17'd255;
	localparam logic [17:0] DIVISOR = 18'd510;
	localparam logic [23:0] GAIN_SAT = 24'd65280;     // 255 * 256
	localparam logic [23:0] GAIN_HALF = 24'd128;

	typedef enum logic [3:0] {
		OP_MUL,
		OP_SCREEN,
		OP_SUB,
		OP_ADD,
		OP_OVERLAY,
		OP_OFFSET,
		OP_GAIN,
		OP_PASS,
		OP_ZERO
	} lane_op_t;

	typedef struct packed {
		logic signed [8:0] channel_offset;
		logic [15:0] channel_gain;
	} cfg_t;

endpackage

// ===== rtl/core/rgb_pixel_blend_unit.sv =====
// top level of the rgb pixel blend unit: command decode, config registers, three lanes
// a result is strobed on done for each accepted command beat
// throughput: one pixel per clock, busy is never raised and the receiver cannot stall
// three register stages: decoded operands, products, result pixel
// reset clears the valid pipe and loads offset 0 and gain 1.0 (256)
module rgb_pixel_blend_unit import rpbu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [3:0] action,
	input  logic [7:0] top_blue,
	input  logic [7:0] top_green,
	input  logic [7:0] top_red,
	input  logic [7:0] bottom_blue,
	input  logic [7:0] bottom_green,
	input  logic [7:0] bottom_red,
	input  logic [7:0] third_green,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [15:0] cfg_data,
	output logic done,
	output logic [7:0] out_blue,
	output logic [7:0] out_green,
	output logic [7:0] out_red
);

	cfg_t cfg_q;
	logic accept;
	logic valid_s1, valid_s2, valid_s3;

	logic [7:0] top_px [NUM_CH];
	logic [7:0] bot_px [NUM_CH];
	lane_op_t op_d [NUM_CH];
	logic [7:0] a_d [NUM_CH];
	logic [7:0] b_d [NUM_CH];
	lane_op_t op_s1 [NUM_CH];
	logic [7:0] a_s1 [NUM_CH];
	logic [7:0] b_s1 [NUM_CH];
	logic [7:0] lane_res [NUM_CH];

	assign busy = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_offset <= OFFSET_RESET;
			cfg_q.channel_gain <= GAIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OFFSET: cfg_q.channel_offset <= $signed(cfg_data[8:0]);
				REG_GAIN: cfg_q.channel_gain <= cfg_data;
				default: ;
			endcase
		end
	end

	// per-lane operation and operand selection
	always_comb begin
		top_px[CH_BLUE] = top_blue;
		top_px[CH_GREEN] = top_green;
		top_px[CH_RED] = top_red;
		bot_px[CH_BLUE] = bottom_blue;
		bot_px[CH_GREEN] = bottom_green;
		bot_px[CH_RED] = bottom_red;
		for (int c = 0; c < NUM_CH; c++) begin
			op_d[c] = OP_PASS;
			a_d[c] = top_px[c];
			b_d[c] = bot_px[c];
			unique case (action)
				ACT_MUL: op_d[c] = OP_MUL;
				ACT_SCREEN: op_d[c] = OP_SCREEN;
				ACT_SUB: op_d[c] = OP_SUB;
				ACT_ADD: op_d[c] = OP_ADD;
				ACT_OVERLAY: op_d[c] = OP_OVERLAY;
				ACT_ONLY_R: a_d[c] = top_red;
				ACT_ONLY_G: a_d[c] = top_green;
				ACT_ONLY_B: a_d[c] = top_blue;
				ACT_ADDCH_R: if (c == CH_RED) op_d[c] = OP_OFFSET;
				ACT_ADDCH_G: if (c == CH_GREEN) op_d[c] = OP_OFFSET;
				ACT_ADDCH_B: if (c == CH_BLUE) op_d[c] = OP_OFFSET;
				ACT_SCALE_R: if (c == CH_RED) op_d[c] = OP_GAIN;
				ACT_SCALE_G: if (c == CH_GREEN) op_d[c] = OP_GAIN;
				ACT_SCALE_B: if (c == CH_BLUE) op_d[c] = OP_GAIN;
				ACT_COMBINE: begin
					if (c == CH_GREEN) a_d[c] = third_green;
					else if (c == CH_BLUE) a_d[c] = bottom_blue;
				end
				default: op_d[c] = OP_ZERO;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= op_d;
			a_s1 <= a_d;
			b_s1 <= b_d;
		end
	end

	for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
		rpbu_lane u_lane (
			.clk(clk),
			.op(op_s1[ch]),
			.a(a_s1[ch]),
			.b(b_s1[ch]),
			.cfg(cfg_q),
			.res(lane_res[ch])
		);
	end

	assign done = valid_s3;
	assign out_blue = lane_res[CH_BLUE];
	assign out_green = lane_res[CH_GREEN];
	assign out_red = lane_res[CH_RED];

	// every command beat comes out as exactly one result beat
	a_beat_out: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##3 done)
		else $error("command beat produced no result beat");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 3))
		else $error("result beat without a command beat");

	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$past(accept && action == ACT_NONE, 3) |->
			(out_blue == 8'd0 && out_green == 8'd0 && out_red == 8'd0))
		else $error("unused action code gave a nonzero pixel");

	a_grey_equal: assert property (@(posedge clk) disable iff (!arst_n)
		$past(accept && (action == ACT_ONLY_R || action == ACT_ONLY_G ||
			action == ACT_ONLY_B), 3) |->
			(out_blue == out_green && out_green == out_red))
		else $error("grey extract gave unequal channels");

endmodule

// ===== rtl/core/rpbu_lane.sv =====
// one color channel of the blend datapath: product stage, then divide and select stage
module rpbu_lane import rpbu_pkg::*; (
	input  logic clk,
	input  lane_op_t op,
	input  logic [7:0] a,
	input  logic [7:0] b,
	input  cfg_t cfg,
	output logic [7:0] res
);

	// stage one: products and the simple ops
	logic [7:0] ma, mb;
	logic [15:0] m;
	logic [15:0] dm;
	logic [15:0] dm2;
	logic [16:0] x;
	logic [23:0] p;
	logic signed [9:0] v;
	logic [7:0] simple;
	logic [8:0] sum;
	logic hi_half;

	lane_op_t op_s2;
	logic [16:0] x_s2;
	logic [23:0] p_s2;
	logic [7:0] simple_s2;

	assign hi_half = b[7];

	always_comb begin
		ma = a;
		mb = b;
		if (op == OP_SCREEN || (op == OP_OVERLAY && hi_half)) begin
			ma = ~a;
			mb = ~b;
		end
		m = ma * mb;
		dm = PROD_MAX - m;
		dm2 = PROD_MAX - {m[14:0], 1'b0};
		case (op)
			OP_MUL: x = {m, 1'b0} + ROUND_BIAS;
			OP_SCREEN: x = {dm, 1'b0} + ROUND_BIAS;
			OP_OVERLAY: begin
				if (hi_half) x = {dm2, 1'b0} + ROUND_BIAS;
				else x = {m[14:0], 2'b00} + ROUND_BIAS;
			end
			default: x = '0;
		endcase
	end

	assign p = 24'(a) * 24'(cfg.channel_gain);
	assign sum = {1'b0, a} + {1'b0, b};
	assign v = $signed({2'b00, a}) + $signed({cfg.channel_offset[8], cfg.channel_offset});

	always_comb begin
		case (op)
			OP_SUB: simple = (a > b) ? a - b : 8'd0;
			OP_ADD: simple = sum[8] ? 8'hFF : sum[7:0];
			OP_OFFSET: begin
				if (v[9]) simple = 8'd0;
				else if (v[8]) simple = 8'hFF;
				else simple = v[7:0];
			end
			OP_PASS: simple = a;
			default: simple = 8'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		op_s2 <= op;
		x_s2 <= x;
		p_s2 <= p;
		simple_s2 <= simple;
	end

	// stage two: x / 510 by reciprocal 16448 / 2^23, low by at most one
	logic [31:0] qm;
	logic [8:0] qe;
	logic [17:0] qx;
	logic [17:0] r;
	logic [8:0] q;
	logic [23:0] pr;
	logic [7:0] g;
	logic [7:0] sel;

	always_comb begin
		qm = 32'({x_s2, 14'b0}) + 32'({x_s2, 6'b0});
		qe = qm[31:23];
		qx = 18'({qe, 9'b0}) - 18'({qe, 1'b0});
		r = 18'(x_s2) - qx;
		q = (r >= DIVISOR) ? qe + 9'd1 : qe;
		pr = p_s2 + GAIN_HALF;
		g = (p_s2 >= GAIN_SAT) ? 8'hFF : pr[15:8];
		case (op_s2)
			OP_MUL, OP_SCREEN, OP_OVERLAY: sel = q[7:0];
			OP_GAIN: sel = g;
			default: sel = simple_s2;
		endcase
	end

	always_ff @(posedge clk) begin
		res <= sel;
	end

endmodule

// ===== sim/tb.sv =====
// self-checking testbench of the rgb pixel blend unit: directed and random pixels against a predictor
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rpbu_pkg::*;

	typedef struct packed {
		logic [3:0] action;
		logic [7:0] top_b;
		logic [7:0] top_g;
		logic [7:0] top_r;
		logic [7:0] bot_b;
		logic [7:0] bot_g;
		logic [7:0] bot_r;
		logic [7:0] green_src;
	} pixel_cmd_t;

	typedef struct packed {
		logic [7:0] b;
		logic [7:0] g;
		logic [7:0] r;
	} bgr_t;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PIXELS_PER_SETTING = 116;
	localparam int NUM_SETTINGS = 8;
	localparam int REPORT_MAX = 10;

	class blend_scoreboard;
		bgr_t pending_pixels[$];
		int offset;
		int gain;
		int failures;
		int compared;

		function new();
			offset = OFFSET_RESET;
			gain = GAIN_RESET;
			failures = 0;
			compared = 0;
		endfunction

		function void set_offset(logic [8:0] raw);
			offset = $signed(raw);
		endfunction

		function void set_gain(logic [15:0] raw);
			gain = raw;
		endfunction

		function int multiply(int a, int b);
			return (2 * a * b + 255) / 510;
		endfunction

		function int screen(int a, int b);
			return (2 * (65025 - (255 - a) * (255 - b)) + 255) / 510;
		endfunction

		function int overlay(int a, int b);
			if (b <= 127)
				return (4 * a * b + 255) / 510;
			return (2 * (65025 - 2 * (255 - a) * (255 - b)) + 255) / 510;
		endfunction

		function int offset_ch(int a);
			int v;
			v = a + offset;
			if (v > 255)
				v = 255;
			if (v < 0)
				v = 0;
			return v;
		endfunction

		// q8.8 gain, saturates once the product reaches 255.0
		function int gain_ch(int a);
			int p;
			p = a * gain;
			if (p >= 255 * 256)
				return 255;
			return (p + 128) >> 8;
		endfunction

		function bgr_t blend(pixel_cmd_t c);
			int ob, og, orr;
			bgr_t px;
			ob = c.top_b;
			og = c.top_g;
			orr = c.top_r;
			case (c.action)
				ACT_MUL: begin
					ob = multiply(c.top_b, c.bot_b);
					og = multiply(c.top_g, c.bot_g);
					orr = multiply(c.top_r, c.bot_r);
				end
				ACT_SCREEN: begin
					ob = screen(c.top_b, c.bot_b);
					og = screen(c.top_g, c.bot_g);
					orr = screen(c.top_r, c.bot_r);
				end
				ACT_SUB: begin
					ob = c.top_b > c.bot_b ? c.top_b - c.bot_b : 0;
					og = c.top_g > c.bot_g ? c.top_g - c.bot_g : 0;
					orr = c.top_r > c.bot_r ? c.top_r - c.bot_r : 0;
				end
				ACT_ADD: begin
					ob = int'(c.top_b) + c.bot_b;
					og = int'(c.top_g) + c.bot_g;
					orr = int'(c.top_r) + c.bot_r;
					if (ob > 255)
						ob = 255;
					if (og > 255)
						og = 255;
					if (orr > 255)
						orr = 255;
				end
				ACT_OVERLAY: begin
					ob = overlay(c.top_b, c.bot_b);
					og = overlay(c.top_g, c.bot_g);
					orr = overlay(c.top_r, c.bot_r);
				end
				ACT_ONLY_R: begin
					ob = c.top_r;
					og = c.top_r;
				end
				ACT_ONLY_G: begin
					ob = c.top_g;
					orr = c.top_g;
				end
				ACT_ONLY_B: begin
					og = c.top_b;
					orr = c.top_b;
				end
				ACT_ADDCH_R: orr = offset_ch(c.top_r);
				ACT_ADDCH_G: og = offset_ch(c.top_g);
				ACT_ADDCH_B: ob = offset_ch(c.top_b);
				ACT_SCALE_R: orr = gain_ch(c.top_r);
				ACT_SCALE_G: og = gain_ch(c.top_g);
				ACT_SCALE_B: ob = gain_ch(c.top_b);
				ACT_COMBINE: begin
					og = c.green_src;
					ob = c.bot_b;
				end
				default: begin
					ob = 0;
					og = 0;
					orr = 0;
				end
			endcase
			px.b = 8'(ob);
			px.g = 8'(og);
			px.r = 8'(orr);
			return px;
		endfunction

		function void log_failure(string what);
			failures++;
			if (failures <= REPORT_MAX)
				$display("[%0t] %s", $realtime, what);
		endfunction

		function void note_pixel(pixel_cmd_t c);
			pending_pixels.insert(pending_pixels.size(), blend(c));
		endfunction

		function void check_pixel(bgr_t got);
			bgr_t want;
			compared++;
			if (pending_pixels.size() == 0) begin
				log_failure($sformatf("unexpected pixel b=%0d g=%0d r=%0d",
					got.b, got.g, got.r));
				return;
			end
			want = pending_pixels.pop_front();
			if (got.b !== want.b || got.g !== want.g || got.r !== want.r)
				log_failure($sformatf(
					"pixel mismatch: expected b=%0d g=%0d r=%0d, got b=%0d g=%0d r=%0d",
					want.b, want.g, want.r, got.b, got.g, got.r));
		endfunction

		function void wrap_up();
			if (pending_pixels.size() != 0)
				log_failure($sformatf("%0d pixels never came out", pending_pixels.size()));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [3:0] action = ACT_MUL;
	logic [7:0] top_blue = '0;
	logic [7:0] top_green = '0;
	logic [7:0] top_red = '0;
	logic [7:0] bottom_blue = '0;
	logic [7:0] bottom_green = '0;
	logic [7:0] bottom_red = '0;
	logic [7:0] third_green = '0;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_OFFSET;
	logic [15:0] cfg_data = '0;
	logic done;
	logic [7:0] out_blue;
	logic [7:0] out_green;
	logic [7:0] out_red;

	blend_scoreboard sb = new();
	int cycles = 0;
	int pixels_sent = 0;
	int settings_used = 1;
	bit steady = 1'b0;

	rgb_pixel_blend_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.top_blue(top_blue),
		.top_green(top_green),
		.top_red(top_red),
		.bottom_blue(bottom_blue),
		.bottom_green(bottom_green),
		.bottom_red(bottom_red),
		.third_green(third_green),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.out_blue(out_blue),
		.out_green(out_green),
		.out_red(out_red)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("rgb_pixel_blend_unit verification failed");
			$finish;
		end
	end

	// every result is taken at the edge that closes its strobe cycle
	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check_pixel({out_blue, out_green, out_red});
		end
	end

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd127;
			3: return 8'd128;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic pixel_cmd_t random_cmd();
		pixel_cmd_t c;
		c.action = 4'($urandom_range(0, 15));
		c.top_b = pick_byte();
		c.top_g = pick_byte();
		c.top_r = pick_byte();
		c.bot_b = pick_byte();
		c.bot_g = pick_byte();
		c.bot_r = pick_byte();
		c.green_src = pick_byte();
		return c;
	endfunction

	function automatic pixel_cmd_t make_cmd(logic [3:0] act, logic [23:0] top_bgr,
			logic [23:0] bot_bgr, logic [7:0] green_src);
		pixel_cmd_t c;
		c.action = act;
		{c.top_b, c.top_g, c.top_r} = top_bgr;
		{c.bot_b, c.bot_g, c.bot_r} = bot_bgr;
		c.green_src = green_src;
		return c;
	endfunction

	task automatic send_pixel(input pixel_cmd_t c);
		start <= 1'b1;
		action <= c.action;
		top_blue <= c.top_b;
		top_green <= c.top_g;
		top_red <= c.top_r;
		bottom_blue <= c.bot_b;
		bottom_green <= c.bot_g;
		bottom_red <= c.bot_r;
		third_green <= c.green_src;
		do @(posedge clk); while (busy);
		sb.note_pixel(c);
		pixels_sent++;
	endtask

	task automatic pause(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send_with_gaps(input pixel_cmd_t c);
		if (!steady && $urandom_range(0, 99) < 12)
			pause(1);
		send_pixel(c);
	endtask

	task automatic drain_pipe();
		start <= 1'b0;
		while (sb.pending_pixels.size() != 0)
			@(posedge clk);
	endtask

	// both registers in random order; upper data bits above the offset are junk on purpose
	task automatic configure(input logic [8:0] offset_raw, input logic [15:0] gain_raw);
		bit gain_first;
		gain_first = $urandom_range(0, 1);
		drain_pipe();
		cfg_we <= 1'b1;
		cfg_index <= gain_first ? REG_GAIN : REG_OFFSET;
		cfg_data <= gain_first ? gain_raw : {7'($urandom), offset_raw};
		@(posedge clk);
		cfg_index <= gain_first ? REG_OFFSET : REG_GAIN;
		cfg_data <= gain_first ? {7'($urandom), offset_raw} : gain_raw;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_offset(offset_raw);
		sb.set_gain(gain_raw);
		settings_used++;
	endtask

	initial begin
		logic [8:0] offsets [NUM_SETTINGS];
		logic [15:0] gains [NUM_SETTINGS];
		offsets = '{9'h100, 9'h0FF, 9'h101, 9'h000, 9'h001, 9'h1FF, 9'h000, 9'h000};
		gains = '{16'hFFFF, 16'h0000, 16'h0100, 16'h00FF, 16'h0101, 16'h8000, 16'h0, 16'h0};
		offsets[6] = 9'($urandom);
		offsets[7] = 9'($urandom);
		gains[6] = 16'($urandom);
		gains[7] = 16'($urandom_range(0, 1023));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every action once at reset register values, mixed extremes per channel
		for (int i = 0; i <= ACT_NONE; i++)
			send_with_gaps(make_cmd(4'(i), {8'd255, 8'd128, 8'd0},
				{8'd127, 8'd128, 8'd255}, 8'h5A));
		send_with_gaps(make_cmd(ACT_MUL, {3{8'd255}}, {3{8'd255}}, 8'h00));
		send_with_gaps(make_cmd(ACT_SCREEN, {3{8'd0}}, {3{8'd0}}, 8'hFF));
		send_with_gaps(make_cmd(ACT_ADD, {3{8'd255}}, {3{8'd255}}, 8'hFF));
		send_with_gaps(make_cmd(ACT_SUB, {3{8'd0}}, {3{8'd255}}, 8'h00));
		send_with_gaps(make_cmd(ACT_OVERLAY, {8'd0, 8'd255, 8'd200},
			{8'd127, 8'd128, 8'd127}, 8'h00));
		send_with_gaps(make_cmd(ACT_COMBINE, {3{8'd0}}, {3{8'd255}}, 8'hA5));

		for (int s = 0; s < NUM_SETTINGS; s++) begin
			configure(offsets[s], gains[s]);
			steady = (s == 2);
			for (int k = 0; k < PIXELS_PER_SETTING; k++)
				send_with_gaps(random_cmd());
		end
		steady = 1'b0;

		drain_pipe();
		pause(DRAIN_CYCLES);
		sb.wrap_up();

		$display("sent %0d pixels over all actions under %0d register settings",
			pixels_sent, settings_used);
		$display("compared %0d result pixels, %0d failures", sb.compared, sb.failures);
		if (sb.failures == 0) begin
			$display("rgb_pixel_blend_unit verification clean");
		end else begin
			$display("rgb_pixel_blend_unit verification failed");
		end
		$finish;
	end

endmodule

// ===== rgb_pixel_blend_unit.f =====
rtl/core/rpbu_pkg.sv
rtl/core/rpbu_lane.sv
rtl/core/rgb_pixel_blend_unit.sv
sim/tb.sv
